// ===== rtl/core/brf_pkg.sv =====
// byte ring fifo package: constants, function codes and transaction structs
// shared by the bank lanes, the merge stage, the top level and the checker
// no dependencies

package brf_pkg;

  localparam int DEPTH_DEF = 4096;
  localparam int LANES_DEF = 8;
  localparam int BANKS     = 8;
  localparam int BANK_W    = $clog2(BANKS);
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 4;
  localparam int FILL_W    = 13;
  localparam int DATA_W    = BANKS * BYTE_W;
  localparam int CAP_W     = 4;

  localparam logic [CAP_W-1:0] CAP_LOG2_RST = 4'd12;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [CNT_W-1:0]   request_count;
    logic [DATA_W-1:0]  write_bytes;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]   granted_count;
    logic [DATA_W-1:0]  read_bytes;
    logic               complete;
    logic [FILL_W-1:0]  fill_level;
  } rsp_t;

  typedef struct packed {
    logic              go;
    logic              wr;
    logic [CNT_W-1:0]  grant;
    logic [BANK_W-1:0] base_lo;
    logic [BANK_W-1:0] mask_lo;
  } bank_ctl_t;

endpackage

// ===== rtl/core/byte_ring_fifo.sv =====
// byte ring fifo top level: pointers, capacity register, control sequence,
// eight banked byte lanes and the merge stage
// depends on brf_pkg, brf_bank, brf_merge
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+------------------
//   command   | in        | start high, busy low         | req_i  (req_t)
//   result    | out       | done_o strobe, one cycle     | rsp_o  (rsp_t)
//   capacity  | in        | cfg_valid_i and cfg_ready_o  | cfg_data_i
//
// each transaction runs from accept through the access state, which accesses
// the banks and registers the read bytes, and the merge state, which passes
// them through the merge into the result register; then the strobe is up
// a new command is accepted in the cycle the previous result is shown
// reset: both pointers zero, capacity 2^12; the byte storage is not cleared
// results cannot be stalled; a capacity write empties the fifo

module byte_ring_fifo #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF,
  parameter int LANES = brf_pkg::LANES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  brf_pkg::req_t              req_i,
  output logic                       done_o,
  output brf_pkg::rsp_t              rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [brf_pkg::CAP_W-1:0]  cfg_data_i
);

  localparam int AW   = $clog2(DEPTH);
  localparam int PW   = AW + 1;
  localparam int CW   = (PW > brf_pkg::CNT_W) ? PW : brf_pkg::CNT_W;
  localparam int RW   = (AW > brf_pkg::BANK_W) ? AW - brf_pkg::BANK_W : 1;
  localparam int ROWS = (AW > brf_pkg::BANK_W) ? DEPTH / brf_pkg::BANKS : 1;
  localparam logic [brf_pkg::CNT_W-1:0] LANES_W = brf_pkg::CNT_W'(LANES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_MERGE
  } state_e;

  state_e                      state_q;
  brf_pkg::func_e              func_q;
  logic [brf_pkg::CNT_W-1:0]   grant_q;
  logic                        complete_q;
  logic [AW-1:0]               base_q;
  logic [brf_pkg::DATA_W-1:0]  wdata_q;
  logic [PW-1:0]               wp_q;
  logic [PW-1:0]               rp_q;
  logic [brf_pkg::CAP_W-1:0]   cap_log2_q;
  logic                        done_q;
  brf_pkg::rsp_t               rsp_q;

  logic [brf_pkg::CAP_W-1:0]   lg_eff;
  logic [PW-1:0]               cap_w;
  logic [AW-1:0]               mask_w;
  logic [PW-1:0]               fill_w;
  logic [PW-1:0]               space_w;
  logic [PW-1:0]               avail_w;
  logic [brf_pkg::CNT_W-1:0]   req_sat;
  logic [brf_pkg::CNT_W-1:0]   grant_d;
  logic [AW-1:0]               base_d;
  logic                        accept;

  brf_pkg::bank_ctl_t          bank_ctl;
  logic [brf_pkg::BYTE_W-1:0]  bank_rdata [brf_pkg::BANKS];
  brf_pkg::rsp_t               merge_rsp;

  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    lg_eff = (cap_log2_q == '0) ? brf_pkg::CAP_W'(1) : cap_log2_q;
    if (int'(lg_eff) >= AW) begin
      cap_w = PW'(DEPTH);
    end else begin
      cap_w = PW'(1) << lg_eff;
    end
    mask_w  = AW'(cap_w - PW'(1));
    fill_w  = wp_q - rp_q;
    space_w = cap_w - fill_w;
    req_sat = (req_i.request_count > LANES_W) ? LANES_W : req_i.request_count;
    avail_w = (req_i.func == brf_pkg::FUNC_WRITE) ? space_w : fill_w;
    if (req_i.func == brf_pkg::FUNC_NOP) begin
      grant_d = '0;
    end else if (CW'(req_sat) < CW'(avail_w)) begin
      grant_d = req_sat;
    end else begin
      grant_d = brf_pkg::CNT_W'(avail_w);
    end
    base_d = (req_i.func == brf_pkg::FUNC_WRITE) ? wp_q[AW-1:0] : rp_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      func_q     <= brf_pkg::FUNC_NOP;
      grant_q    <= '0;
      complete_q <= 1'b0;
      base_q     <= '0;
      wdata_q    <= '0;
      wp_q       <= '0;
      rp_q       <= '0;
      cap_log2_q <= brf_pkg::CAP_LOG2_RST;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            cap_log2_q <= cfg_data_i;
            wp_q       <= '0;
            rp_q       <= '0;
          end
          if (accept) begin
            func_q     <= req_i.func;
            grant_q    <= grant_d;
            complete_q <= grant_d == req_i.request_count;
            base_q     <= base_d;
            wdata_q    <= req_i.write_bytes;
            state_q    <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          if (func_q == brf_pkg::FUNC_WRITE) begin
            wp_q <= wp_q + PW'(grant_q);
          end
          if (func_q == brf_pkg::FUNC_READ) begin
            rp_q <= rp_q + PW'(grant_q);
          end
          state_q <= S_MERGE;
        end
        S_MERGE: begin
          rsp_q   <= merge_rsp;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    bank_ctl.go      = state_q == S_ACCESS;
    bank_ctl.wr      = func_q == brf_pkg::FUNC_WRITE;
    bank_ctl.grant   = grant_q;
    bank_ctl.base_lo = brf_pkg::BANK_W'(base_q);
    bank_ctl.mask_lo = brf_pkg::BANK_W'(mask_w);
  end

  for (genvar b = 0; b < brf_pkg::BANKS; b++) begin : g_bank
    brf_bank #(
      .AW       (AW),
      .RW       (RW),
      .ROWS     (ROWS),
      .BANK_IDX (b)
    ) u_bank (
      .clk_i   (clk_i),
      .ctl_i   (bank_ctl),
      .base_i  (base_q),
      .mask_i  (mask_w),
      .wdata_i (wdata_q),
      .rdata_o (bank_rdata[b])
    );
  end

  brf_merge u_merge (
    .bank_rdata_i (bank_rdata),
    .rd_i         ((func_q == brf_pkg::FUNC_READ) || (func_q == brf_pkg::FUNC_PEEK)),
    .grant_i      (grant_q),
    .base_lo_i    (bank_ctl.base_lo),
    .mask_lo_i    (bank_ctl.mask_lo),
    .complete_i   (complete_q),
    .fill_i       (brf_pkg::FILL_W'(fill_w)),
    .rsp_o        (merge_rsp)
  );

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/core/brf_bank.sv =====
// one byte bank of the ring: works out which lane it serves, its row,
// and does the write or the registered read for that lane
// depends on brf_pkg

module brf_bank #(
  parameter int AW       = 12,
  parameter int RW       = 9,
  parameter int ROWS     = 512,
  parameter int BANK_IDX = 0
) (
  input  logic                        clk_i,
  input  brf_pkg::bank_ctl_t          ctl_i,
  input  logic [AW-1:0]               base_i,
  input  logic [AW-1:0]               mask_i,
  input  logic [brf_pkg::DATA_W-1:0]  wdata_i,
  output logic [brf_pkg::BYTE_W-1:0]  rdata_o
);

  logic [brf_pkg::BYTE_W-1:0] mem_q [ROWS];
  logic [brf_pkg::BYTE_W-1:0] rdata_q;
  logic [brf_pkg::BANK_W-1:0] lane;
  logic [brf_pkg::BANK_W-1:0] bank_id;
  logic                       in_range;
  logic                       act;
  logic [AW-1:0]              offset;
  logic [RW-1:0]              row;
  logic [brf_pkg::BYTE_W-1:0] wbyte;

  assign bank_id  = brf_pkg::BANK_W'(BANK_IDX);
  assign lane     = (bank_id - ctl_i.base_lo) & ctl_i.mask_lo;
  assign in_range = (bank_id & ~ctl_i.mask_lo) == '0;
  assign act      = ctl_i.go && in_range &&
                    (brf_pkg::CNT_W'(lane) < ctl_i.grant);
  assign offset   = (base_i + AW'(lane)) & mask_i;
  assign row      = RW'(offset >> brf_pkg::BANK_W);
  assign wbyte    = wdata_i[brf_pkg::BYTE_W*int'(lane) +: brf_pkg::BYTE_W];

  always_ff @(posedge clk_i) begin
    if (act && ctl_i.wr) begin
      mem_q[row] <= wbyte;
    end
    if (act && !ctl_i.wr) begin
      rdata_q <= mem_q[row];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/brf_merge.sv =====
// merge stage: rotates the bank read bytes back into lane order,
// zeroes lanes beyond the grant, and all lanes of a write, and forms the result transaction
// depends on brf_pkg

module brf_merge (
  input  logic [brf_pkg::BYTE_W-1:0] bank_rdata_i [brf_pkg::BANKS],
  input  logic                       rd_i,
  input  logic [brf_pkg::CNT_W-1:0]  grant_i,
  input  logic [brf_pkg::BANK_W-1:0] base_lo_i,
  input  logic [brf_pkg::BANK_W-1:0] mask_lo_i,
  input  logic                       complete_i,
  input  logic [brf_pkg::FILL_W-1:0] fill_i,
  output brf_pkg::rsp_t              rsp_o
);

  logic [brf_pkg::DATA_W-1:0] bytes;

  always_comb begin
    logic [brf_pkg::BANK_W-1:0] sel;
    bytes = '0;
    for (int j = 0; j < brf_pkg::BANKS; j++) begin
      sel = (base_lo_i + brf_pkg::BANK_W'(j)) & mask_lo_i;
      if (rd_i && (brf_pkg::CNT_W'(j) < grant_i)) begin
        bytes[brf_pkg::BYTE_W*j +: brf_pkg::BYTE_W] = bank_rdata_i[sel];
      end
    end
  end

  always_comb begin
    rsp_o.granted_count = grant_i;
    rsp_o.read_bytes    = bytes;
    rsp_o.complete      = complete_i;
    rsp_o.fill_level    = fill_i;
  end

endmodule

// ===== rtl/core/brf_checker.sv =====
// port-level checker for the byte ring fifo, bound to the top level
// depends on brf_pkg and byte_ring_fifo

module brf_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  brf_pkg::req_t              req_i,
  input  logic                       done_o,
  input  brf_pkg::rsp_t              rsp_o,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_o,
  input  logic [brf_pkg::CAP_W-1:0]  cfg_data_i
);

  // every accepted command gives its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing three cycles after accept");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of a transaction");

  a_zero_grant_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.granted_count == '0)) |-> (rsp_o.read_bytes == '0))
    else $error("read data present with zero grant");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for byte_ring_fifo: directed and random write, read,
// peek and nop commands under several ring capacities, results checked in order
// depends on brf_pkg and byte_ring_fifo

class ring_tracker;
  logic [brf_pkg::BYTE_W-1:0] ring_copy [brf_pkg::DEPTH_DEF];
  logic [brf_pkg::FILL_W-1:0] wr_ptr;
  logic [brf_pkg::FILL_W-1:0] rd_ptr;
  logic [brf_pkg::CAP_W-1:0]  cap_log2;
  brf_pkg::rsp_t              pending [$];
  int                         errors;

  function new();
    wr_ptr   = '0;
    rd_ptr   = '0;
    cap_log2 = brf_pkg::CAP_LOG2_RST;
    errors   = 0;
  endfunction

  function void load_capacity(logic [brf_pkg::CAP_W-1:0] value);
    cap_log2 = value;
    wr_ptr   = '0;
    rd_ptr   = '0;
  endfunction

  function int ring_size();
    int lg;
    int sz;
    lg = (cap_log2 == 0) ? 1 : int'(cap_log2);
    sz = 1 << lg;
    if (sz > brf_pkg::DEPTH_DEF) sz = brf_pkg::DEPTH_DEF;
    return sz;
  endfunction

  // work out the response of one accepted command and queue it
  function void note_command(brf_pkg::req_t cmd);
    int sz;
    int used;
    int want;
    int grant;
    logic [brf_pkg::FILL_W-1:0] diff;
    brf_pkg::rsp_t exp_rsp;
    sz      = ring_size();
    diff    = wr_ptr - rd_ptr;
    used    = int'(diff);
    want    = (cmd.request_count > brf_pkg::LANES_DEF) ? brf_pkg::LANES_DEF
                                                        : int'(cmd.request_count);
    grant   = 0;
    exp_rsp = '0;
    case (cmd.func)
      brf_pkg::FUNC_WRITE: begin
        grant = (want < sz - used) ? want : sz - used;
        for (int i = 0; i < grant; i++) begin
          ring_copy[(int'(wr_ptr) + i) & (sz - 1)] = cmd.write_bytes[8*i +: 8];
        end
        wr_ptr = wr_ptr + brf_pkg::FILL_W'(grant);
      end
      brf_pkg::FUNC_READ, brf_pkg::FUNC_PEEK: begin
        grant = (want < used) ? want : used;
        for (int i = 0; i < grant; i++) begin
          exp_rsp.read_bytes[8*i +: 8] = ring_copy[(int'(rd_ptr) + i) & (sz - 1)];
        end
        if (cmd.func == brf_pkg::FUNC_READ) rd_ptr = rd_ptr + brf_pkg::FILL_W'(grant);
      end
      default: grant = 0;
    endcase
    exp_rsp.granted_count = brf_pkg::CNT_W'(grant);
    exp_rsp.complete      = (grant == int'(cmd.request_count));
    exp_rsp.fill_level    = wr_ptr - rd_ptr;
    pending.push_back(exp_rsp);
  endfunction

  function void compare_field(string field, logic [brf_pkg::DATA_W-1:0] want,
                              logic [brf_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(brf_pkg::rsp_t got);
    brf_pkg::rsp_t want;
    if (pending.size() == 0) begin
      $display("%0t: result with no command pending, actual %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    compare_field("granted_count", brf_pkg::DATA_W'(want.granted_count),
                  brf_pkg::DATA_W'(got.granted_count));
    compare_field("read_bytes", want.read_bytes, got.read_bytes);
    compare_field("complete", brf_pkg::DATA_W'(want.complete),
                  brf_pkg::DATA_W'(got.complete));
    compare_field("fill_level", brf_pkg::DATA_W'(want.fill_level),
                  brf_pkg::DATA_W'(got.fill_level));
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  brf_pkg::req_t             req_i = '0;
  logic                      done_o;
  brf_pkg::rsp_t             rsp_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [brf_pkg::CAP_W-1:0] cfg_data_i = '0;

  ring_tracker tracker;
  int          cycle_count = 0;

  byte_ring_fifo i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(rsp_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic brf_pkg::req_t make_cmd(brf_pkg::func_e fn, int count,
                                             logic [brf_pkg::DATA_W-1:0] data);
    brf_pkg::req_t cmd;
    cmd.func          = fn;
    cmd.request_count = brf_pkg::CNT_W'(count);
    cmd.write_bytes   = data;
    return cmd;
  endfunction

  function automatic brf_pkg::req_t random_cmd(int write_pct, bit full_writes);
    brf_pkg::req_t cmd;
    int            pick;
    pick             = $urandom_range(99);
    cmd.write_bytes  = {$urandom, $urandom};
    if (pick < write_pct) cmd.func = brf_pkg::FUNC_WRITE;
    else if (pick >= 97) cmd.func = brf_pkg::FUNC_NOP;
    else if ($urandom_range(3) == 0) cmd.func = brf_pkg::FUNC_PEEK;
    else cmd.func = brf_pkg::FUNC_READ;
    if ($urandom_range(9) == 0) begin
      cmd.request_count = brf_pkg::CNT_W'($urandom_range(15));
    end else if (full_writes && cmd.func == brf_pkg::FUNC_WRITE) begin
      cmd.request_count = brf_pkg::CNT_W'(brf_pkg::LANES_DEF);
    end else begin
      cmd.request_count = brf_pkg::CNT_W'($urandom_range(brf_pkg::LANES_DEF));
    end
    return cmd;
  endfunction

  // returns at the edge that accepts the command, start still high
  task automatic issue(brf_pkg::req_t cmd);
    start <= 1'b1;
    req_i <= cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_command(cmd);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [brf_pkg::CAP_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.load_capacity(value);
  endtask

  initial begin
    logic [brf_pkg::CAP_W-1:0] caps [12];
    int                        write_pct;
    int                        burst_left;
    bit                        steady;
    caps    = '{4'd12, 4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd13, 4'd4, 4'd5, 4'd8, 4'd14, 4'd6};
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty, full-lane, oversized and nop commands at reset capacity
    issue(make_cmd(brf_pkg::FUNC_READ, 8, '0));
    issue(make_cmd(brf_pkg::FUNC_PEEK, 8, '0));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 0, '1));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 8, '1));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 15, '0));
    issue(make_cmd(brf_pkg::FUNC_PEEK, 8, '0));
    issue(make_cmd(brf_pkg::FUNC_READ, 15, '0));
    issue(make_cmd(brf_pkg::FUNC_READ, 3, '1));
    issue(make_cmd(brf_pkg::FUNC_PEEK, 0, '0));
    issue(make_cmd(brf_pkg::FUNC_NOP, 0, '1));
    issue(make_cmd(brf_pkg::FUNC_NOP, 5, '0));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 5, 64'h0123_4567_89ab_cdef));
    issue(make_cmd(brf_pkg::FUNC_READ, 8, '0));

    // two-byte ring: full, wrap, then the zero register value
    write_capacity(4'd1);
    issue(make_cmd(brf_pkg::FUNC_WRITE, 8, 64'ha5a5_a5a5_a5a5_a5a5));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 1, 64'h5a));
    issue(make_cmd(brf_pkg::FUNC_PEEK, 1, '0));
    issue(make_cmd(brf_pkg::FUNC_READ, 8, '0));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 3, 64'h33_2211));
    issue(make_cmd(brf_pkg::FUNC_READ, 2, '0));
    write_capacity(4'd0);
    issue(make_cmd(brf_pkg::FUNC_WRITE, 2, 64'hbeef));
    issue(make_cmd(brf_pkg::FUNC_READ, 1, '0));
    issue(make_cmd(brf_pkg::FUNC_WRITE, 1, 64'h77));
    issue(make_cmd(brf_pkg::FUNC_READ, 8, '0));

    for (int p = 0; p < 12; p++) begin
      write_capacity(caps[p]);
      write_pct  = (p == 0) ? 95 : 30 + 20 * $urandom_range(2);
      steady     = ($urandom_range(3) == 0);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < ((p == 0) ? 620 : 45); n++) begin
        issue(random_cmd(write_pct, p == 0));
        burst_left--;
        if (burst_left == 0) begin
          if (!steady) pause($urandom_range(1, 8));
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/brf_pkg.sv
rtl/core/brf_bank.sv
rtl/core/brf_merge.sv
rtl/core/byte_ring_fifo.sv
rtl/core/brf_checker.sv
tb/tb_top.sv
